/* hw/rtl/bblc_pkg.sv */
package bblc_pkg;

    localparam int KEY_W    = 18;
    localparam int SIZE_W   = 40;
    localparam int USED_W   = 48;
    localparam int HOLD_W   = 8;
    localparam int STATUS_W = 4;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        KIND_LOOKUP  = 2'd0,
        KIND_INSERT  = 2'd1,
        KIND_RELEASE = 2'd2,
        KIND_DROP    = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_HIT      = 4'd0,
        ST_MISS     = 4'd1,
        ST_INSERTED = 4'd2,
        ST_REPLACED = 4'd3,
        ST_RELEASED = 4'd4,
        ST_NOTFOUND = 4'd5,
        ST_DISABLED = 4'd6,
        ST_EVICTED  = 4'd7,
        ST_FULL     = 4'd8,
        ST_DROPPED  = 4'd9
    } status_t;

    localparam logic [CFG_IDX_W-1:0] CFG_DISABLED  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNLIMITED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BUDGET    = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_APPLY,
        S_VSCAN,
        S_EVICT,
        S_DONE,
        S_FLUSH
    } state_t;

endpackage

/* hw/rtl/byte_budget_lru_cache.sv */
// channel | ports                                               | direction
// --------+-----------------------------------------------------+----------
// command | start, busy (out), kind, layer_index, expert_index, | in
//         | item_bytes, caller_keeps                             |
// result  | result_valid, status, out_layer, out_expert,         | out
//         | out_size, used_total, last                           |
// config  | cfg_we, cfg_index, cfg_data                          | in
//
// for each accepted item the key search walks
// the slot memory one entry a cycle (one read port), then the apply state
// an insert over budget adds one walk for the oldest unheld slot
// per eviction, plus one more walk that finds none or the flush state for the last result
// a disabled item is answered from idle and never raises busy
// each result holds for one cycle under result_valid; the receiver cannot stall
// reset clears control, valid bits, byte count and use clock at once
// slot key, size, tick and holder counts live in one memory, one entry per read
module byte_budget_lru_cache #(
    parameter int ENTRIES    = 32,
    parameter int CLOCK_BITS = 48
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         kind,
    input  logic [7:0]                         layer_index,
    input  logic [9:0]                         expert_index,
    input  logic [39:0]                        item_bytes,
    input  logic                               caller_keeps,
    output logic                               result_valid,
    output logic [3:0]                         status,
    output logic [7:0]                         out_layer,
    output logic [9:0]                         out_expert,
    output logic [39:0]                        out_size,
    output logic [47:0]                        used_total,
    output logic                               last,
    input  logic                               cfg_we,
    input  logic [bblc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [47:0]                        cfg_data
);
    import bblc_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);

    // slot record packed into one memory word
    typedef struct packed {
        logic [KEY_W-1:0]      key;
        logic [SIZE_W-1:0]     size;
        logic [CLOCK_BITS-1:0] tick;
        logic [HOLD_W-1:0]     holders;
    } slot_t;

    slot_t slot_mem [ENTRIES];
    slot_t rd_data_reg;
    logic  mem_we;
    logic [IDX_W-1:0] mem_waddr;
    slot_t mem_wdata;
    logic [IDX_W-1:0] mem_raddr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= slot_mem[mem_raddr];
    end

    // config registers
    logic                   disabled_reg;
    logic                   unlimited_reg;
    logic [USED_W-1:0]      budget_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disabled_reg  <= 1'b0;
            unlimited_reg <= 1'b1;
            budget_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DISABLED:  disabled_reg  <= cfg_data[0];
                CFG_UNLIMITED: unlimited_reg <= cfg_data[0];
                CFG_BUDGET:    budget_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    state_t state_reg, state_next;
    logic [ENTRIES-1:0]     valid_reg, valid_next;
    logic [USED_W-1:0]      used_reg, used_next;
    logic [CLOCK_BITS-1:0]  clock_reg, clock_next;
    logic [CNT_W-1:0]       scan_reg, scan_next;     // address issued
    logic                   rd_ok_reg, rd_ok_next;   // read data valid
    logic [IDX_W-1:0]       rd_idx_reg, rd_idx_next; // index of read data
    logic                   found_reg, found_next;
    logic [IDX_W-1:0]       hit_idx_reg, hit_idx_next;
    slot_t                  hit_reg, hit_next;
    logic                   vic_ok_reg, vic_ok_next;
    logic [IDX_W-1:0]       vic_idx_reg, vic_idx_next;
    slot_t                  vic_reg, vic_next;
    kind_t                  kind_reg;
    logic [KEY_W-1:0]       key_reg;
    logic [SIZE_W-1:0]      size_reg;
    logic                   keeps_reg;

    // result held back until the next victim walk tells whether it is the last
    logic [STATUS_W-1:0]    pend_st_reg, pend_st_next;
    logic [KEY_W-1:0]       pend_key_reg, pend_key_next;
    logic [SIZE_W-1:0]      pend_size_reg, pend_size_next;
    logic [USED_W-1:0]      pend_used_reg, pend_used_next;

    logic                   rv_next;
    logic [STATUS_W-1:0]    st_next;
    logic [KEY_W-1:0]       okey_next;
    logic [SIZE_W-1:0]      osize_next;
    logic [USED_W-1:0]      oused_next;
    logic                   last_next;
    logic [KEY_W-1:0]       okey_reg;

    logic [IDX_W-1:0]       free_idx;
    logic                   free_ok;

    always_comb
    begin
        free_idx = '0;
        free_ok  = 1'b0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = IDX_W'(i);
                free_ok  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            kind_reg  <= kind_t'(kind);
            key_reg   <= {layer_index, expert_index};
            size_reg  <= item_bytes;
            keeps_reg <= caller_keeps;
        end
        hit_reg       <= hit_next;
        hit_idx_reg   <= hit_idx_next;
        vic_reg       <= vic_next;
        vic_idx_reg   <= vic_idx_next;
        rd_idx_reg    <= rd_idx_next;
        pend_st_reg   <= pend_st_next;
        pend_key_reg  <= pend_key_next;
        pend_size_reg <= pend_size_next;
        pend_used_reg <= pend_used_next;
        okey_reg      <= okey_next;
        out_size      <= osize_next;
        used_total    <= oused_next;
        status        <= st_next;
        last          <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            valid_reg    <= '0;
            used_reg     <= '0;
            clock_reg    <= '0;
            scan_reg     <= '0;
            rd_ok_reg    <= 1'b0;
            found_reg    <= 1'b0;
            vic_ok_reg   <= 1'b0;
            result_valid <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            used_reg     <= used_next;
            clock_reg    <= clock_next;
            scan_reg     <= scan_next;
            rd_ok_reg    <= rd_ok_next;
            found_reg    <= found_next;
            vic_ok_reg   <= vic_ok_next;
            result_valid <= rv_next;
        end
    end

    assign busy       = (state_reg != S_IDLE);
    assign out_layer  = okey_reg[KEY_W-1:10];
    assign out_expert = okey_reg[9:0];

    always_comb
    begin
        logic [CLOCK_BITS-1:0] tick;
        logic [USED_W-1:0]     u;
        tick = clock_reg + CLOCK_BITS'(1);
        u    = used_reg;

        state_next     = state_reg;
        valid_next     = valid_reg;
        used_next      = used_reg;
        clock_next     = clock_reg;
        scan_next      = scan_reg;
        rd_ok_next     = 1'b0;
        rd_idx_next    = rd_idx_reg;
        found_next     = found_reg;
        hit_idx_next   = hit_idx_reg;
        hit_next       = hit_reg;
        vic_ok_next    = vic_ok_reg;
        vic_idx_next   = vic_idx_reg;
        vic_next       = vic_reg;
        pend_st_next   = pend_st_reg;
        pend_key_next  = pend_key_reg;
        pend_size_next = pend_size_reg;
        pend_used_next = pend_used_reg;
        mem_we         = 1'b0;
        mem_waddr      = hit_idx_reg;
        mem_wdata      = hit_reg;
        mem_raddr      = scan_reg[IDX_W-1:0];
        rv_next        = 1'b0;
        st_next        = status;
        okey_next      = key_reg;
        osize_next     = '0;
        oused_next     = used_total;
        last_next      = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    okey_next = {layer_index, expert_index};
                    if (disabled_reg)
                    begin
                        rv_next    = 1'b1;
                        st_next    = ST_DISABLED;
                        oused_next = used_reg;
                    end
                    else
                    begin
                        state_next = S_FIND;
                        scan_next  = '0;
                        found_next = 1'b0;
                    end
                end
            end
            // walk the memory for the key, one entry a cycle
            S_FIND:
            begin
                if (rd_ok_reg && !found_reg && valid_reg[rd_idx_reg]
                    && rd_data_reg.key == key_reg)
                begin
                    found_next   = 1'b1;
                    hit_idx_next = rd_idx_reg;
                    hit_next     = rd_data_reg;
                end
                if (scan_reg < CNT_W'(ENTRIES))
                begin
                    mem_raddr   = scan_reg[IDX_W-1:0];
                    rd_ok_next  = 1'b1;
                    rd_idx_next = scan_reg[IDX_W-1:0];
                    scan_next   = scan_reg + CNT_W'(1);
                end
                else if (!rd_ok_reg)
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                rv_next    = 1'b1;
                state_next = S_IDLE;
                case (kind_reg)
                    KIND_LOOKUP:
                    begin
                        if (!found_reg)
                        begin
                            st_next = ST_MISS;
                        end
                        else
                        begin
                            st_next    = ST_HIT;
                            osize_next = hit_reg.size;
                            clock_next = tick;
                            mem_we     = 1'b1;
                            mem_wdata  = hit_reg;
                            mem_wdata.tick = tick;
                            if (hit_reg.holders != '1)
                            begin
                                mem_wdata.holders = hit_reg.holders + HOLD_W'(1);
                            end
                        end
                    end
                    KIND_RELEASE:
                    begin
                        if (!found_reg)
                        begin
                            st_next = ST_NOTFOUND;
                        end
                        else
                        begin
                            st_next    = ST_RELEASED;
                            osize_next = hit_reg.size;
                            used_next  = used_reg - USED_W'(hit_reg.size);
                            valid_next[hit_idx_reg] = 1'b0;
                        end
                    end
                    KIND_DROP:
                    begin
                        if (!found_reg)
                        begin
                            st_next = ST_NOTFOUND;
                        end
                        else
                        begin
                            st_next   = ST_DROPPED;
                            mem_we    = 1'b1;
                            mem_wdata = hit_reg;
                            if (hit_reg.holders != '0)
                            begin
                                mem_wdata.holders = hit_reg.holders - HOLD_W'(1);
                            end
                        end
                    end
                    default:
                    begin
                        if (!found_reg && !free_ok)
                        begin
                            st_next = ST_FULL;
                        end
                        else
                        begin
                            if (found_reg)
                            begin
                                st_next = ST_REPLACED;
                                u = used_reg - USED_W'(hit_reg.size);
                            end
                            else
                            begin
                                st_next   = ST_INSERTED;
                                mem_waddr = free_idx;
                            end
                            u          = u + USED_W'(size_reg);
                            used_next  = u;
                            osize_next = size_reg;
                            clock_next = tick;
                            mem_we     = 1'b1;
                            mem_wdata.key     = key_reg;
                            mem_wdata.size    = size_reg;
                            mem_wdata.tick    = tick;
                            mem_wdata.holders = HOLD_W'(keeps_reg);
                            valid_next[mem_waddr] = 1'b1;
                            // over budget: hold the result until a victim walk
                            // shows whether more results follow
                            if (!unlimited_reg && u > budget_reg)
                            begin
                                rv_next        = 1'b0;
                                pend_st_next   = st_next;
                                pend_key_next  = key_reg;
                                pend_size_next = size_reg;
                                pend_used_next = u;
                                state_next     = S_DONE;
                            end
                        end
                    end
                endcase
                oused_next = used_next;
            end
            // gap state so the memory write lands before the next walk
            S_DONE:
            begin
                state_next  = S_VSCAN;
                scan_next   = '0;
                vic_ok_next = 1'b0;
            end
            // walk for the oldest unheld slot
            S_VSCAN:
            begin
                if (rd_ok_reg && valid_reg[rd_idx_reg] && rd_data_reg.holders == '0
                    && (!vic_ok_reg || rd_data_reg.tick < vic_reg.tick))
                begin
                    vic_ok_next  = 1'b1;
                    vic_idx_next = rd_idx_reg;
                    vic_next     = rd_data_reg;
                end
                if (scan_reg < CNT_W'(ENTRIES))
                begin
                    rd_ok_next  = 1'b1;
                    rd_idx_next = scan_reg[IDX_W-1:0];
                    scan_next   = scan_reg + CNT_W'(1);
                end
                else if (!rd_ok_reg)
                begin
                    state_next = S_EVICT;
                end
            end
            // send the held result; it is the last one when no victim was found
            S_EVICT:
            begin
                rv_next    = 1'b1;
                st_next    = pend_st_reg;
                okey_next  = pend_key_reg;
                osize_next = pend_size_reg;
                oused_next = pend_used_reg;
                last_next  = !vic_ok_reg;
                state_next = S_IDLE;
                if (vic_ok_reg)
                begin
                    u          = used_reg - USED_W'(vic_reg.size);
                    used_next  = u;
                    valid_next[vic_idx_reg] = 1'b0;
                    pend_st_next   = ST_EVICTED;
                    pend_key_next  = vic_reg.key;
                    pend_size_next = vic_reg.size;
                    pend_used_next = u;
                    if (u > budget_reg)
                    begin
                        state_next  = S_VSCAN;
                        scan_next   = '0;
                        vic_ok_next = 1'b0;
                    end
                    else
                    begin
                        state_next = S_FLUSH;
                    end
                end
            end
            // budget met: the held eviction is the final result
            S_FLUSH:
            begin
                rv_next    = 1'b1;
                st_next    = pend_st_reg;
                okey_next  = pend_key_reg;
                osize_next = pend_size_reg;
                oused_next = pend_used_reg;
                last_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
